>>> sv/thp_pkg.sv
// Shared types and constants for the tree height block.
// No dependencies; every other file imports this package.
package thp_pkg;

    localparam int PARENT_W = 11;
    localparam int HEIGHT_W = 11;

    // Parent code of a root node (-1 in eleven bits)
    localparam logic [PARENT_W-1:0] ROOT_CODE = 11'h7FF;

    typedef enum logic [1:0] {
        S_LOAD,
        S_WALK,
        S_HOLD
    } set_state_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_ISSUE,
        W_EVAL,
        W_DONE
    } walk_state_t;

    // Control from the loader to the walker
    typedef struct packed {
        logic                wr_en;
        logic [PARENT_W-1:0] wr_data;
        logic                start;
        logic                root_seen;
    } walk_ctl_t;

endpackage

>>> sv/thp_in_if.sv
// Input channel: one node's parent index per transfer.
// Depends on thp_pkg.
interface thp_in_if import thp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [PARENT_W-1:0] parent;
    logic                       last;

    modport source (output valid, output parent, output last, input ready);
    modport sink   (input valid, input parent, input last, output ready);
endinterface

>>> sv/thp_out_if.sv
// Output channel: one height result per node set.
// Depends on thp_pkg.
interface thp_out_if import thp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height;
    logic                bad_parent;

    modport source (output valid, output height, output bad_parent, input ready);
    modport sink   (input valid, input height, input bad_parent, output ready);
endinterface

>>> sv/tree_height_from_parents.sv
// Tree height from a parent array: top level with the load side and the result register.
// Depends on thp_pkg, thp_in_if, thp_out_if and thp_walker.
//
// Nodes are loaded one per cycle, node i being the i-th transfer of a set;
// parent -1 marks a root, the transfer with last high closes the set. The
// block then drops ready and walks each node up its parent chain through a
// single read port of the parent and depth memories: every link followed
// takes a memory read, then a compare and add, and a walk stops at
// the root (the last root of the set), at a node whose depth is already
// known, at a bad link, or after node-count steps when the chain loops.
// The result becomes valid in the output register once every node is walked,
// or without a walk when the set has no root, and ready returns at that same
// edge; while the output register is still full, both wait until it drains.
// Parent indices at or beyond the node count raise bad_parent. A result may
// wait in the output register while the next set loads. No clearing pass is
// needed after reset.
module tree_height_from_parents import thp_pkg::*; #(
    parameter int MAX_NODES = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    thp_in_if.sink     nodes,
    thp_out_if.source  result
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int WW = (CW > HEIGHT_W) ? CW : HEIGHT_W;

    set_state_t state_reg, state_next;

    logic [CW-1:0]         node_count_reg, node_count_next;
    logic [AW-1:0]         root_index_reg, root_index_next;
    logic                  root_seen_reg, root_seen_next;
    logic [PARENT_W-2:0]   max_parent_reg, max_parent_next;
    logic                  neg_bad_reg, neg_bad_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HEIGHT_W-1:0]   out_height_reg, out_height_next;
    logic                  out_bad_reg, out_bad_next;

    logic                  in_xfer;
    logic                  store;
    logic                  slot_free;
    logic                  emit;
    logic [PARENT_W-1:0]   parent_raw;
    walk_ctl_t             ctl;
    logic                  walk_done;
    logic [CW-1:0]         walk_height;
    logic [WW-1:0]         height_wide;
    logic                  set_bad;

    assign in_xfer    = nodes.valid && nodes.ready;
    assign store      = in_xfer && (node_count_reg != CW'(MAX_NODES));
    assign parent_raw = nodes.parent;
    assign slot_free  = !out_valid_reg || result.ready;

    assign ctl.wr_en     = store;
    assign ctl.wr_data   = parent_raw;
    assign ctl.start     = in_xfer && nodes.last;
    // Include a root carried by the closing transfer itself
    assign ctl.root_seen = root_seen_next;

    thp_walker #(
        .MAX_NODES (MAX_NODES)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .node_count (node_count_reg),
        .root_index (root_index_reg),
        .done       (walk_done),
        .height     (walk_height)
    );

    assign height_wide = WW'(walk_height);
    assign set_bad     = neg_bad_reg || (WW'(max_parent_reg) >= WW'(node_count_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            node_count_reg <= '0;
            root_index_reg <= '0;
            root_seen_reg  <= 1'b0;
            max_parent_reg <= '0;
            neg_bad_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            root_index_reg <= root_index_next;
            root_seen_reg  <= root_seen_next;
            max_parent_reg <= max_parent_next;
            neg_bad_reg    <= neg_bad_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_height_reg <= out_height_next;
        out_bad_reg    <= out_bad_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        root_index_next = root_index_reg;
        root_seen_next  = root_seen_reg;
        max_parent_next = max_parent_reg;
        neg_bad_next    = neg_bad_reg;
        out_height_next = out_height_reg;
        out_bad_next    = out_bad_reg;
        emit            = 1'b0;

        if (store)
        begin
            node_count_next = node_count_reg + CW'(1);
            if (parent_raw == ROOT_CODE)
            begin
                root_index_next = node_count_reg[AW-1:0];
                root_seen_next  = 1'b1;
            end
            else if (parent_raw[PARENT_W-1])
            begin
                neg_bad_next = 1'b1;
            end
            else if (parent_raw[PARENT_W-2:0] > max_parent_reg)
            begin
                max_parent_next = parent_raw[PARENT_W-2:0];
            end
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_xfer && nodes.last)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    if (slot_free)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Hand the result to the output register and start an empty set
        if (emit)
        begin
            out_height_next = height_wide[HEIGHT_W-1:0];
            out_bad_next    = set_bad;
            node_count_next = '0;
            root_index_next = '0;
            root_seen_next  = 1'b0;
            max_parent_next = '0;
            neg_bad_next    = 1'b0;
            state_next      = S_LOAD;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign nodes.ready       = (state_reg == S_LOAD);
    assign result.valid      = out_valid_reg;
    assign result.height     = out_height_reg;
    assign result.bad_parent = out_bad_reg;

endmodule

>>> sv/thp_walker.sv
// Parent and depth memories plus the sequencer that walks each node up to the root.
// Depends on thp_pkg.
module thp_walker import thp_pkg::*; #(
    parameter int MAX_NODES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  walk_ctl_t                          ctl,
    input  logic [$clog2(MAX_NODES+1)-1:0]     node_count,
    input  logic [$clog2(MAX_NODES)-1:0]       root_index,
    output logic                               done,
    output logic [$clog2(MAX_NODES+1)-1:0]     height
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int WW = (CW > PARENT_W) ? CW : PARENT_W;

    logic [PARENT_W-1:0] parent_mem [MAX_NODES];
    logic [CW-1:0]       depth_mem  [MAX_NODES];
    logic [PARENT_W-1:0] parent_rd;
    logic [CW-1:0]       depth_rd;

    walk_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [CW-1:0] height_reg, height_next;

    logic          depth_we;
    logic [CW-1:0] node_depth;
    logic          is_root;
    logic          is_known;
    logic          bad_link;
    logic          at_limit;

    // Parent store: written while loading, read during the walk
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            parent_mem[node_count[AW-1:0]] <= ctl.wr_data;
        end
        parent_rd <= parent_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[idx_reg[AW-1:0]] <= node_depth;
        end
        depth_rd <= depth_mem[cur_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_IDLE;
            idx_reg    <= '0;
            cur_reg    <= '0;
            steps_reg  <= '0;
            height_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cur_reg    <= cur_next;
            steps_reg  <= steps_next;
            height_reg <= height_next;
        end
    end

    assign is_root  = (cur_reg == root_index);
    // Nodes with an index below the one being walked already have their depth stored
    assign is_known = (CW'(cur_reg) < idx_reg);
    assign bad_link = parent_rd[PARENT_W-1] || (WW'(parent_rd) >= WW'(node_count));
    assign at_limit = (steps_reg == node_count);

    always_comb
    begin
        if (is_root)
        begin
            node_depth = steps_reg + CW'(1);
        end
        else if (is_known && (depth_rd != '0))
        begin
            node_depth = depth_rd + steps_reg;
        end
        else
        begin
            node_depth = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        height_next = height_reg;
        depth_we    = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            W_IDLE:
            begin
                if (ctl.start)
                begin
                    idx_next    = '0;
                    cur_next    = '0;
                    steps_next  = '0;
                    height_next = '0;
                    state_next  = ctl.root_seen ? W_ISSUE : W_DONE;
                end
            end
            W_ISSUE:
            begin
                state_next = W_EVAL;
            end
            W_EVAL:
            begin
                if (is_root || is_known || bad_link || at_limit)
                begin
                    depth_we = 1'b1;
                    if (node_depth > height_reg)
                    begin
                        height_next = node_depth;
                    end
                    if ((idx_reg + CW'(1)) == node_count)
                    begin
                        state_next = W_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        cur_next   = AW'(idx_reg + CW'(1));
                        steps_next = '0;
                        state_next = W_ISSUE;
                    end
                end
                else
                begin
                    // Follow the parent link
                    cur_next   = AW'(parent_rd[PARENT_W-2:0]);
                    steps_next = steps_reg + CW'(1);
                    state_next = W_ISSUE;
                end
            end
            W_DONE:
            begin
                done       = 1'b1;
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    assign height = height_reg;

endmodule

>>> tb/tb_tree_height_from_parents.sv
// Self-checking testbench for tree_height_from_parents: streams parent-index sets
// into the block and checks each height and bad_parent result against an in-bench predictor.
// Depends on thp_pkg, thp_in_if, thp_out_if and the RTL top level.
module tb_tree_height_from_parents;
    import thp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CAP = 1024;
    localparam int SET_BUF  = 64;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                bad_parent;
    } tree_result_t;

    logic clk;
    logic rst_n;

    thp_in_if  nodes_if ();
    thp_out_if result_if ();

    tree_height_from_parents #(.MAX_NODES(NODE_CAP)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .nodes  (nodes_if),
        .result (result_if)
    );

    // Predictor state: the set being loaded and the per-walk depth memo
    logic [PARENT_W-1:0] tree_par [NODE_CAP];
    int unsigned         tree_depth [NODE_CAP];
    bit                  tree_depth_known [NODE_CAP];
    int unsigned         tree_nodes;
    int unsigned         tree_root;
    bit                  tree_has_root;

    tree_result_t pending_heights [$];

    int  fail_count;
    bit  idle_on;
    int  random_nodes;
    int  sets_closed;
    int  nodes_sent;
    int  bad_sets;
    int  rootless_sets;
    int  oversize_sets;
    int  tallest;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Depth of one node in nodes from the root; 0 when its chain misses the root
    function automatic int unsigned node_depth(int unsigned start);
        int unsigned cur;
        int unsigned steps;
        logic [PARENT_W-1:0] up;
        cur = start;
        steps = 0;
        while (steps <= tree_nodes) begin
            if (cur == tree_root)
                return steps + 1;
            if (tree_depth_known[cur]) begin
                if (tree_depth[cur] == 0)
                    return 0;
                return tree_depth[cur] + steps;
            end
            up = tree_par[cur];
            if (up[PARENT_W-1] || up >= tree_nodes)
                return 0;
            cur = up;
            steps++;
        end
        return 0;
    endfunction

    function automatic tree_result_t close_tree();
        tree_result_t r;
        int unsigned  best;
        int unsigned  d;
        logic [PARENT_W-1:0] q;
        best = 0;
        r.bad_parent = 1'b0;
        for (int unsigned i = 0; i < tree_nodes; i++) begin
            q = tree_par[i];
            if (q != ROOT_CODE && (q[PARENT_W-1] || q >= tree_nodes))
                r.bad_parent = 1'b1;
        end
        if (tree_has_root) begin
            for (int unsigned i = 0; i < tree_nodes; i++) begin
                d = node_depth(i);
                tree_depth[i] = d;
                tree_depth_known[i] = 1'b1;
                if (d > best)
                    best = d;
            end
        end
        r.height = HEIGHT_W'(best);
        sets_closed++;
        if (r.bad_parent)
            bad_sets++;
        if (!tree_has_root)
            rootless_sets++;
        if (best > tallest)
            tallest = best;
        for (int i = 0; i < NODE_CAP; i++)
            tree_depth_known[i] = 1'b0;
        tree_nodes = 0;
        tree_root = 0;
        tree_has_root = 1'b0;
        return r;
    endfunction

    // Apply one accepted transfer to the predictor
    function automatic void load_parent(logic [PARENT_W-1:0] p, bit is_last);
        tree_result_t closed;
        if (tree_nodes < NODE_CAP) begin
            tree_par[tree_nodes] = p;
            if (p == ROOT_CODE) begin
                tree_root = tree_nodes;
                tree_has_root = 1'b1;
            end
            tree_nodes++;
        end else if (is_last) begin
            oversize_sets++;
        end
        if (is_last) begin
            closed = close_tree();
            pending_heights = {pending_heights, closed};
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_node(input logic [PARENT_W-1:0] p, input bit is_last);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            nodes_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        nodes_if.valid  <= 1'b1;
        nodes_if.parent <= p;
        nodes_if.last   <= is_last;
        do
            @(posedge clk);
        while (!nodes_if.ready);
        nodes_sent++;
        load_parent(p, is_last);
    endtask

    // Short sets covering each special case by hand
    task automatic test_small_shapes();
        // lone root
        send_node(ROOT_CODE, 1'b1);
        // lone node pointing at itself: no root
        send_node(11'd0, 1'b1);
        // straight chain, root first
        send_node(ROOT_CODE, 1'b0);
        send_node(11'd0, 1'b0);
        send_node(11'd1, 1'b0);
        send_node(11'd2, 1'b1);
        // chain with the root at the end
        send_node(11'd1, 1'b0);
        send_node(11'd2, 1'b0);
        send_node(11'd3, 1'b0);
        send_node(ROOT_CODE, 1'b1);
        // two nodes pointing at each other, no root
        send_node(11'd1, 1'b0);
        send_node(11'd0, 1'b1);
        // two roots: the later one wins
        send_node(ROOT_CODE, 1'b0);
        send_node(11'd0, 1'b0);
        send_node(ROOT_CODE, 1'b0);
        send_node(11'd2, 1'b0);
        send_node(11'd2, 1'b1);
        // root plus a detached cycle
        send_node(ROOT_CODE, 1'b0);
        send_node(11'd0, 1'b0);
        send_node(11'd3, 1'b0);
        send_node(11'd2, 1'b1);
        // parent equal to the node count
        send_node(ROOT_CODE, 1'b0);
        send_node(11'd0, 1'b0);
        send_node(11'd3, 1'b1);
        // largest positive index and negatives other than a root
        send_node(ROOT_CODE, 1'b0);
        send_node(11'h3FF, 1'b0);
        send_node(11'h400, 1'b0);
        send_node(11'h7FE, 1'b1);
    endtask

    // Full-capacity set, including transfers past the node limit
    task automatic test_oversize_sets();
        // chain of the full depth, then dropped noise; the last dropped transfer closes it
        for (int i = 0; i < NODE_CAP + 6; i++) begin
            if (i >= NODE_CAP)
                send_node(PARENT_W'($urandom_range(0, 2047)), i == NODE_CAP + 5);
            else if (i == 0)
                send_node(ROOT_CODE, 1'b0);
            else
                send_node(PARENT_W'(i - 1), 1'b0);
        end
    endtask

    task automatic send_random_set();
        logic [PARENT_W-1:0] plist [SET_BUF];
        int order [SET_BUF];
        int n;
        int kind;
        int j;
        int tmp;
        int idx;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, SET_BUF) : $urandom_range(1, 24);
        kind = $urandom_range(0, 9);
        if (kind < 9) begin
            // well-formed tree over a shuffled node order
            for (int i = 0; i < n; i++)
                order[i] = i;
            for (int i = n - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            plist[order[0]] = ROOT_CODE;
            for (int k = 1; k < n; k++) begin
                j = ($urandom_range(0, 2) == 0) ? k - 1 : $urandom_range(0, k - 1);
                plist[order[k]] = PARENT_W'(order[j]);
            end
            // break a few links in some of them
            if (kind >= 7) begin
                repeat ($urandom_range(1, 3)) begin
                    idx = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 4))
                        0: plist[idx] = ROOT_CODE;
                        1: plist[idx] = PARENT_W'(idx);
                        2: plist[idx] = PARENT_W'($urandom_range(n, 1023));
                        3: plist[idx] = PARENT_W'($urandom_range(1024, 2046));
                        default: plist[idx] = PARENT_W'($urandom_range(0, n - 1));
                    endcase
                end
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0: plist[i] = PARENT_W'($urandom_range(0, 2047));
                    1: plist[i] = ROOT_CODE;
                    default: plist[i] = PARENT_W'($urandom_range(0, n));
                endcase
            end
        end
        for (int i = 0; i < n; i++)
            send_node(plist[i], i == n - 1);
        random_nodes += n;
    endtask

    task automatic test_random_forests();
        idle_on = 1'b0;
        while (random_nodes < 100)
            send_random_set();
        idle_on = 1'b1;
        while (random_nodes < 550)
            send_random_set();
    endtask

    // Result checker: compare every transfer with the oldest prediction
    initial begin
        tree_result_t want;
        forever begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready) begin
                if (pending_heights.size() == 0) begin
                    $display("%0t: unexpected result height=%0d bad_parent=%0b",
                             $time, result_if.height, result_if.bad_parent);
                    fail_count++;
                end else begin
                    want = pending_heights.pop_front();
                    if (result_if.height !== want.height) begin
                        $display("%0t: height mismatch: expected %0d, actual %0d",
                                 $time, want.height, result_if.height);
                        fail_count++;
                    end
                    if (result_if.bad_parent !== want.bad_parent) begin
                        $display("%0t: bad_parent mismatch: expected %0b, actual %0b",
                                 $time, want.bad_parent, result_if.bad_parent);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result-side backpressure
    initial begin
        int r;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!idle_on) begin
                result_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    result_if.ready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge clk);
                end else begin
                    result_if.ready <= (r >= 30);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("%0t: timeout, %0d results still pending", $time, pending_heights.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        rst_n           <= 1'b0;
        nodes_if.valid  <= 1'b0;
        nodes_if.parent <= '0;
        nodes_if.last   <= 1'b0;
        idle_on       = 1'b0;
        fail_count    = 0;
        random_nodes  = 0;
        sets_closed   = 0;
        nodes_sent    = 0;
        bad_sets      = 0;
        rootless_sets = 0;
        oversize_sets = 0;
        tallest       = 0;
        tree_nodes    = 0;
        tree_root     = 0;
        tree_has_root = 1'b0;
        for (int i = 0; i < NODE_CAP; i++)
            tree_depth_known[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_shapes();
        idle_on = 1'b1;
        test_oversize_sets();
        test_random_forests();

        nodes_if.valid <= 1'b0;
        wait (pending_heights.size() == 0);
        // catch any stray result after the last expected one
        repeat (100) @(posedge clk);

        $display("Sent %0d nodes in %0d sets: %0d with a bad parent, %0d rootless, %0d oversized.",
                 nodes_sent, sets_closed, bad_sets, rootless_sets, oversize_sets);
        $display("Tallest tree seen: %0d nodes; %0d mismatches.", tallest, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
sv/thp_pkg.sv
sv/thp_in_if.sv
sv/thp_out_if.sv
sv/thp_walker.sv
sv/tree_height_from_parents.sv
tb/tb_tree_height_from_parents.sv
